// ===== hdl/mwsa_pkg.sv =====
// ----------------------------------------------------------------------------
// mwsa_pkg
// Shared widths, controller states and the command/status bundles of the
// moving window sum and average block.
// ----------------------------------------------------------------------------
package mwsa_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 32;   // Q16.16 input sample
  localparam int SUM_W    = 40;   // Q24.16 moving sum
  localparam int AVG_W    = 32;   // Q16.16 moving average
  localparam int CFG_W    = 9;    // window size register

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_LOAD,
    ST_DIVIDE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture accepted sample, clear on start of series
    logic update;     // update running total, ring, count and slot
    logic div_start;  // load divider with total and count
    logic out_load;   // move finished result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;   // divider holds the final quotient
    logic out_busy;   // output register full and not being taken
  } sts_t;

endpackage

// ===== hdl/mwsa_ram.sv =====
// ----------------------------------------------------------------------------
// mwsa_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mwsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/mwsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// mwsa_ctrl
// Sequencer: takes one sample, reads the oldest ring entry, updates the
// running total, runs the divider and hands the result to the output register.
// ----------------------------------------------------------------------------
module mwsa_ctrl
  import mwsa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_READ;
        end
      end
      // ring read address settles, read data registered
      ST_READ: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (sts.div_done && !sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/mwsa_dp.sv =====
// ----------------------------------------------------------------------------
// mwsa_dp
// Datapath: window size register, sample ring, running total, fill count,
// bit-serial signed divider and the output register.
// ----------------------------------------------------------------------------
module mwsa_dp
  import mwsa_pkg::*;
#(
  parameter int WINDOW_MAX = 256
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [SAMPLE_W-1:0]     s_tdata,
  input  logic                    s_tuser,
  input  logic                    cfg_wen,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    m_tready,
  output logic                    m_tvalid,
  output logic [SUM_W+AVG_W-1:0]  m_tdata,
  input  cmd_t                    cmd,
  output sts_t                    sts
);

  localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int OS_W   = CNT_W + 1;
  localparam int TOT_W  = SAMPLE_W + $clog2(WINDOW_MAX);
  localparam int EXT_W  = (TOT_W > SUM_W) ? TOT_W : SUM_W;
  localparam int ITER_W = $clog2(TOT_W + 1);

  localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(40'sh7F_FFFF_FFFF);
  localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(40'sh80_0000_0000);

  logic [CFG_W-1:0]          window_size;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [TOT_W-1:0]   total;
  logic [CNT_W-1:0]          fill;
  logic [SLOT_W-1:0]         slot;

  logic [CMP_W-1:0]          cfg_ext;
  logic [CMP_W-1:0]          w_eff;
  logic                      full;
  logic [OS_W-1:0]           slot_ext;
  logic [OS_W-1:0]           fill_ext;
  logic [OS_W-1:0]           old_ext;
  logic [SLOT_W-1:0]         old_slot;
  logic [SAMPLE_W-1:0]       ram_rdata;
  logic signed [SAMPLE_W-1:0] old_smp;
  logic signed [TOT_W-1:0]   total_upd;
  logic [SLOT_W-1:0]         slot_inc;

  logic [TOT_W-1:0]          quo;
  logic [CNT_W-1:0]          rem;
  logic [CNT_W-1:0]          div_d;
  logic [ITER_W-1:0]         iter;
  logic                      neg;
  logic [CNT_W:0]            rem_sh;
  logic                      q_bit;
  logic [TOT_W-1:0]          total_mag;

  logic signed [EXT_W-1:0]   tot_ext;
  logic signed [SUM_W-1:0]   sum_sat;
  logic [AVG_W-1:0]          avg_val;
  logic [SUM_W-1:0]          out_sum;
  logic [AVG_W-1:0]          out_avg;

  // Window size register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= CFG_W'(1);
    end else if (cfg_wen) begin
      window_size <= cfg_wdata;
    end
  end

  // Effective window: zero acts as one, clamp to ring depth
  always_comb begin
    cfg_ext = CMP_W'(window_size);
    if (cfg_ext == '0) begin
      w_eff = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(WINDOW_MAX)) begin
      w_eff = CMP_W'(WINDOW_MAX);
    end else begin
      w_eff = cfg_ext;
    end
  end

  assign full = (CMP_W'(fill) >= w_eff);

  // Slot of the oldest sample held
  always_comb begin
    slot_ext = OS_W'(slot);
    fill_ext = OS_W'(fill);
    if (slot_ext >= fill_ext) begin
      old_ext = slot_ext - fill_ext;
    end else begin
      old_ext = slot_ext + OS_W'(WINDOW_MAX) - fill_ext;
    end
  end

  assign old_slot = old_ext[SLOT_W-1:0];
  assign slot_inc = (slot == SLOT_W'(WINDOW_MAX - 1)) ? '0 : slot + 1'b1;

  // Sample ring
  mwsa_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (slot),
    .wdata (sample_q),
    .raddr (old_slot),
    .rdata (ram_rdata)
  );

  // New total: add the sample, drop the oldest once the window is full
  assign old_smp   = $signed(ram_rdata);
  assign total_upd = full ? (total - TOT_W'(old_smp) + TOT_W'(sample_q))
                          : (total + TOT_W'(sample_q));

  // Sample capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_q <= $signed(s_tdata);
    end
  end

  // Running total, fill count and write slot
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      fill  <= '0;
      slot  <= '0;
    end else if (cmd.load && s_tuser) begin
      total <= '0;
      fill  <= '0;
      slot  <= '0;
    end else if (cmd.update) begin
      total <= total_upd;
      slot  <= slot_inc;
      if (!full) begin
        fill <= fill + 1'b1;
      end
    end
  end

  // Divider: restoring, one quotient bit per cycle on magnitudes
  assign total_mag = total[TOT_W-1] ? TOT_W'(-total) : TOT_W'(total);
  assign rem_sh    = {rem, quo[TOT_W-1]};
  assign q_bit     = (rem_sh >= {1'b0, div_d});

  always_ff @(posedge clk) begin
    if (rst) begin
      iter <= '0;
    end else if (cmd.div_start) begin
      iter <= ITER_W'(TOT_W);
    end else if (iter != '0) begin
      iter <= iter - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo   <= total_mag;
      rem   <= '0;
      div_d <= fill;
      neg   <= total[TOT_W-1];
    end else if (iter != '0) begin
      quo <= {quo[TOT_W-2:0], q_bit};
      if (q_bit) begin
        rem <= CNT_W'(rem_sh - {1'b0, div_d});
      end else begin
        rem <= rem_sh[CNT_W-1:0];
      end
    end
  end

  // Sum saturation and signed quotient
  assign tot_ext = EXT_W'(total);
  always_comb begin
    if (tot_ext > SAT_HI) begin
      sum_sat = SUM_W'(SAT_HI);
    end else if (tot_ext < SAT_LO) begin
      sum_sat = SUM_W'(SAT_LO);
    end else begin
      sum_sat = SUM_W'(tot_ext);
    end
  end

  assign avg_val = neg ? (AVG_W'(0) - quo[AVG_W-1:0]) : quo[AVG_W-1:0];

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sum <= sum_sat;
      out_avg <= avg_val;
    end
  end

  assign m_tdata      = {out_avg, out_sum};
  assign sts.div_done = (iter == '0);
  assign sts.out_busy = m_tvalid && !m_tready;

endmodule

// ===== hdl/moving_window_sum_and_average_top.sv =====
// ----------------------------------------------------------------------------
// moving_window_sum_and_average_top
// Simple moving average over signed Q16.16 samples: moving sum and average.
// ----------------------------------------------------------------------------
// Each sample on the input stream yields one result: the sum of the most
// recent window_size samples (Q24.16, saturated to 40 bits) and that sum
// divided by the number of samples held, truncated toward zero (Q16.16).
// s_tuser high marks the first sample of a new series and empties the window
// first. One sample is in work at a time: the block takes no new sample before
// it is through with the last, and its bit-serial divider forms one quotient
// bit per cycle. A finished result waits in the output register while the
// next sample is taken. The user must write the window size register only
// while the block is idle; the block does not enforce it. Zero acts as one
// and values above WINDOW_MAX act as WINDOW_MAX. No clearing pass after reset.
// ----------------------------------------------------------------------------
module moving_window_sum_and_average_top
  import mwsa_pkg::*;
#(
  parameter int WINDOW_MAX = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  // sample stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [SAMPLE_W-1:0]    s_tdata,    // [31:0] sample
  input  logic                   s_tuser,    // [0] start_of_series
  // result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [SUM_W+AVG_W-1:0] m_tdata,    // [39:0] moving_sum, [71:40] moving_average
  // window size register
  input  logic                   cfg_wen,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  mwsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  mwsa_dp #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

`ifndef SYNTHESIS
  // One sample at a time: no new transaction right after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while a sample is still in work");

  // A held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(m_tvalid && !m_tready))
    else $error("output register overwritten before it was taken");

  // A result only appears from a finished division
  a_result_from_div: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.div_done)
    else $error("result loaded before the division finished");

  // Output valid rises only after a result load
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.out_load))
    else $error("output valid rose without a result load");
`endif

endmodule
